>>> hdl/xml_entity_escaper_macros.svh
// Assertion macros for the XML entity escaper.
// Users of these macros must have clk and arst_n in scope.
`ifndef XML_ENTITY_ESCAPER_MACROS_SVH
`define XML_ENTITY_ESCAPER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked only outside reset.
`define XEE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define XEE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define XEE_ASSERT(lbl, prop, msg)
`define XEE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hdl/xee_pkg.sv
package xee_pkg;

	// Default depth of the queue between front and back.
	localparam int XEE_QDEPTH = 4;

	// Characters that take part in escaping.
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_G  = 8'h67;
	localparam logic [7:0] CH_LO_L  = 8'h6C;
	localparam logic [7:0] CH_LO_M  = 8'h6D;
	localparam logic [7:0] CH_LO_O  = 8'h6F;
	localparam logic [7:0] CH_LO_P  = 8'h70;
	localparam logic [7:0] CH_LO_Q  = 8'h71;
	localparam logic [7:0] CH_LO_S  = 8'h73;
	localparam logic [7:0] CH_LO_T  = 8'h74;
	localparam logic [7:0] CH_LO_U  = 8'h75;

	// How one input byte is rendered.
	typedef enum logic [2:0] {
		KIND_PLAIN,
		KIND_AMP,
		KIND_LT,
		KIND_GT,
		KIND_APOS,
		KIND_QUOT,
		KIND_NUM
	} xee_kind_t;

	// A classified byte, ready to be spelled out.
	typedef struct packed {
		xee_kind_t  kind;
		logic [7:0] raw;
		logic       hund_two;
		logic [3:0] tens;
		logic [3:0] ones;
		logic       str_end;
	} xee_entry_t;

	// A queue slot with its presence bit.
	typedef struct packed {
		logic       valid;
		xee_entry_t entry;
	} xee_slot_t;

	// Index of the final character of a rendering.
	function automatic logic [2:0] last_index(input xee_kind_t kind);
		logic [2:0] r;
		unique case (kind)
			KIND_PLAIN:    r = 3'd0;
			KIND_LT, KIND_GT: r = 3'd3;
			KIND_AMP:      r = 3'd4;
			default:       r = 3'd5;
		endcase
		return r;
	endfunction

	// Character at position idx of the rendering of e.
	function automatic logic [7:0] char_at(input xee_entry_t e, input logic [2:0] idx);
		logic [7:0] c;
		c = CH_AMP;
		if (idx == 3'd5) begin
			c = CH_SEMI;
		end else begin
			unique case (e.kind)
				KIND_PLAIN: c = e.raw;
				KIND_AMP: begin
					case (idx)
						3'd1:    c = CH_LO_A;
						3'd2:    c = CH_LO_M;
						3'd3:    c = CH_LO_P;
						3'd4:    c = CH_SEMI;
						default: c = CH_AMP;
					endcase
				end
				KIND_LT, KIND_GT: begin
					case (idx)
						3'd1:    c = (e.kind == KIND_LT) ? CH_LO_L : CH_LO_G;
						3'd2:    c = CH_LO_T;
						3'd3:    c = CH_SEMI;
						default: c = CH_AMP;
					endcase
				end
				KIND_APOS: begin
					case (idx)
						3'd1:    c = CH_LO_A;
						3'd2:    c = CH_LO_P;
						3'd3:    c = CH_LO_O;
						3'd4:    c = CH_LO_S;
						default: c = CH_AMP;
					endcase
				end
				KIND_QUOT: begin
					case (idx)
						3'd1:    c = CH_LO_Q;
						3'd2:    c = CH_LO_U;
						3'd3:    c = CH_LO_O;
						3'd4:    c = CH_LO_T;
						default: c = CH_AMP;
					endcase
				end
				KIND_NUM: begin
					case (idx)
						3'd1:    c = CH_HASH;
						3'd2:    c = CH_ZERO | {6'd0, e.hund_two, !e.hund_two};
						3'd3:    c = CH_ZERO | {4'd0, e.tens};
						3'd4:    c = CH_ZERO | {4'd0, e.ones};
						default: c = CH_AMP;
					endcase
				end
				default: c = e.raw;
			endcase
		end
		return c;
	endfunction

endpackage

>>> hdl/xee_if.sv
// Input channel: one text byte per beat.
interface xee_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       string_end;

	modport source(output valid, output in_byte, output string_end, input ready);
	modport sink(input valid, input in_byte, input string_end, output ready);
endinterface

// Output channel: one escaped character per beat.
interface xee_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       run_last;
	logic       string_end_out;

	modport source(output valid, output out_char, output run_last, output string_end_out,
		input ready);
	modport sink(input valid, input out_char, input run_last, input string_end_out,
		output ready);
endinterface

>>> hdl/xee_front.sv
module xee_front (
	xee_in_if.sink              text,
	input  logic                full,
	output xee_pkg::xee_slot_t  push
);
	import xee_pkg::*;

	logic [7:0]  rem;
	logic [6:0]  rem7;
	logic [14:0] prod;
	logic [3:0]  tens;
	logic [6:0]  tens_x10;
	logic [6:0]  ones_w;
	xee_kind_t   kind;

	// A beat is taken whenever the queue has room.
	assign text.ready = !full;

	// Markup characters get named entities; the upper half gets a number.
	always_comb begin
		unique case (text.in_byte)
			CH_AMP:  kind = KIND_AMP;
			CH_LT:   kind = KIND_LT;
			CH_GT:   kind = KIND_GT;
			CH_APOS: kind = KIND_APOS;
			CH_QUOT: kind = KIND_QUOT;
			default: kind = text.in_byte[7] ? KIND_NUM : KIND_PLAIN;
		endcase
	end

	// Decimal digits of a byte from 128 to 255: hundreds by compare, tens by
	// reciprocal multiply (exact for values below 100), ones by subtraction.
	assign rem      = (text.in_byte >= 8'd200) ? (text.in_byte - 8'd200)
		: (text.in_byte - 8'd100);
	assign rem7     = rem[6:0];
	assign prod     = {8'd0, rem7} * 15'd205;
	assign tens     = prod[14:11];
	assign tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
	assign ones_w   = rem7 - tens_x10;

	always_comb begin
		push.valid          = text.valid && !full;
		push.entry.kind     = kind;
		push.entry.raw      = text.in_byte;
		push.entry.hund_two = text.in_byte >= 8'd200;
		push.entry.tens     = tens;
		push.entry.ones     = ones_w[3:0];
		push.entry.str_end  = text.string_end;
	end

endmodule

>>> hdl/xee_queue.sv
`include "xml_entity_escaper_macros.svh"

module xee_queue #(
	parameter int DEPTH = xee_pkg::XEE_QDEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  xee_pkg::xee_slot_t push,
	output logic               full,
	output xee_pkg::xee_slot_t head,
	input  logic               pop
);
	import xee_pkg::*;

	localparam int IDXW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	xee_entry_t      mem_q [DEPTH];
	logic [IDXW-1:0] wr_ptr_q;
	logic [IDXW-1:0] rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign full       = count_q == CNTW'(DEPTH);
	assign head.valid = count_q != '0;
	assign head.entry = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == IDXW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == IDXW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push.valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	`XEE_ASSERT(a_count_bound, count_q <= CNTW'(DEPTH), "queue count beyond depth")
	`XEE_ASSERT(a_no_overflow, push.valid |-> count_q != CNTW'(DEPTH), "push into full queue")
	`XEE_ASSERT(a_no_underflow, pop |-> count_q != '0, "pop from empty queue")

endmodule

>>> hdl/xee_back.sv
`include "xml_entity_escaper_macros.svh"

module xee_back (
	input  logic               clk,
	input  logic               arst_n,
	input  xee_pkg::xee_slot_t head,
	output logic               pop,
	xee_out_if.source          escaped
);
	import xee_pkg::*;

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       run_last_q;
	logic       end_q;
	logic [2:0] last_idx;
	logic       is_last;
	logic       load;

	// Walk the rendering of the head entry, one character per free output slot.
	assign last_idx = last_index(head.entry.kind);
	assign is_last  = idx_q == last_idx;
	assign load     = head.valid && (!out_valid_q || escaped.ready);
	assign pop      = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= is_last ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (escaped.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q <= char_at(head.entry, idx_q);
			run_last_q <= is_last;
			end_q      <= is_last && head.entry.str_end;
		end
	end

	assign escaped.valid          = out_valid_q;
	assign escaped.out_char       = out_char_q;
	assign escaped.run_last       = run_last_q;
	assign escaped.string_end_out = end_q;

	`XEE_ASSERT(a_idx_needs_head, idx_q != '0 |-> head.valid, "mid-entry with empty queue")
	`XEE_ASSERT(a_head_held, idx_q != '0 |-> $stable(head.entry), "head changed mid-entry")
	`XEE_ASSERT(a_end_is_last, escaped.valid && escaped.string_end_out |-> escaped.run_last,
		"string end on a character that is not last")

endmodule

>>> hdl/xml_entity_escaper.sv
// XML entity escaper. Text bytes enter on the text channel, one per beat, and
// escaped characters leave on the escaped channel, one per beat. The five markup
// characters become named entities of four to six characters, and bytes 128 to
// 255 become a six-character reference of the form &#NNN;. The output emits one
// character per cycle while escaped.ready is high, and an escaped byte takes as
// many beats as it has characters; that character emitter is what sets the
// sustained rate. A queue of QDEPTH classified bytes lets the input keep taking
// beats while the emitter spells out an entity. A taken byte passes the queue
// and then the output register before its first character appears.
module xml_entity_escaper #(
	parameter int QDEPTH = xee_pkg::XEE_QDEPTH
) (
	input logic        clk,
	input logic        arst_n,
	xee_in_if.sink     text,
	xee_out_if.source  escaped
);
	import xee_pkg::*;

	xee_slot_t push;
	xee_slot_t head;
	logic      full;
	logic      pop;

	xee_front u_front (
		.text (text),
		.full (full),
		.push (push)
	);

	xee_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.head   (head),
		.pop    (pop)
	);

	xee_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.escaped (escaped)
	);

endmodule
